/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/nesmix_pkg.sv */
`timescale 1ns / 1ps
package nesmix_pkg;

    // voice slots in the phase memory
    localparam logic [1:0] VOICE_P1  = 2'd0;
    localparam logic [1:0] VOICE_P2  = 2'd1;
    localparam logic [1:0] VOICE_TRI = 2'd2;
    localparam logic [1:0] VOICE_NSE = 2'd3;

    // sound register addresses that a tick reads
    localparam logic [3:0] REG_P1_CTL = 4'd0;
    localparam logic [3:0] REG_P1_LO  = 4'd2;
    localparam logic [3:0] REG_P1_HI  = 4'd3;
    localparam logic [3:0] REG_P2_CTL = 4'd4;
    localparam logic [3:0] REG_P2_LO  = 4'd6;
    localparam logic [3:0] REG_P2_HI  = 4'd7;
    localparam logic [3:0] REG_TRI_LO = 4'd10;
    localparam logic [3:0] REG_TRI_HI = 4'd11;
    localparam logic [3:0] REG_NSE_VOL = 4'd12;
    localparam logic [3:0] REG_NSE_PER = 4'd14;

    // number of registers fetched per tick
    localparam int unsigned FETCH_COUNT = 10;

    localparam logic FLAG_TICK  = 1'b0;
    localparam logic FLAG_WRITE = 1'b1;

    // fetch slot to register address
    function automatic logic [3:0] fetch_addr(input logic [3:0] slot);
        logic [3:0] a;
        case (slot)
            4'd0:    a = REG_P1_CTL;
            4'd1:    a = REG_P1_LO;
            4'd2:    a = REG_P1_HI;
            4'd3:    a = REG_P2_CTL;
            4'd4:    a = REG_P2_LO;
            4'd5:    a = REG_P2_HI;
            4'd6:    a = REG_TRI_LO;
            4'd7:    a = REG_TRI_HI;
            4'd8:    a = REG_NSE_VOL;
            4'd9:    a = REG_NSE_PER;
            default: a = REG_P1_CTL;
        endcase
        return a;
    endfunction

    // noise period in cpu cycles
    function automatic logic [11:0] noise_period(input logic [3:0] idx);
        logic [11:0] p;
        case (idx)
            4'd0:    p = 12'd4;
            4'd1:    p = 12'd8;
            4'd2:    p = 12'd16;
            4'd3:    p = 12'd32;
            4'd4:    p = 12'd64;
            4'd5:    p = 12'd96;
            4'd6:    p = 12'd128;
            4'd7:    p = 12'd160;
            4'd8:    p = 12'd202;
            4'd9:    p = 12'd254;
            4'd10:   p = 12'd380;
            4'd11:   p = 12'd508;
            4'd12:   p = 12'd762;
            4'd13:   p = 12'd1016;
            4'd14:   p = 12'd2034;
            default: p = 12'd4068;
        endcase
        return p;
    endfunction

    // floor(32767 * vol / 150)
    function automatic logic [11:0] noise_amp(input logic [3:0] vol);
        logic [11:0] a;
        case (vol)
            4'd0:    a = 12'd0;
            4'd1:    a = 12'd218;
            4'd2:    a = 12'd436;
            4'd3:    a = 12'd655;
            4'd4:    a = 12'd873;
            4'd5:    a = 12'd1092;
            4'd6:    a = 12'd1310;
            4'd7:    a = 12'd1529;
            4'd8:    a = 12'd1747;
            4'd9:    a = 12'd1966;
            4'd10:   a = 12'd2184;
            4'd11:   a = 12'd2402;
            4'd12:   a = 12'd2621;
            4'd13:   a = 12'd2839;
            4'd14:   a = 12'd3058;
            default: a = 12'd3276;
        endcase
        return a;
    endfunction

endpackage

/* src/nes_apu_tone_mixer_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// four-voice tone generator and mixer
// input stream: each word is a register write (tuser = 1) or a sample tick (tuser = 0)
// a write lands in the sound register file in the cycle it is accepted and gives no result
// a tick gives one output word: the pulse/triangle mix and the noise level
// output stream: m_tdata carries mixed_level (bits 14..0) and noise_level (bits 26..15)
// cycles_per_sample is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this
// a tick runs through the register fetch, then per voice the period load, the phase read,
// one bit-serial modulo step per phase bit and the update (no modulo steps when the
// voice's period is zero), then the mix steps, the bit-serial divide and the output state
// one tick is in flight at a time: no word is taken until the last tick has loaded its
// result into the output register
// a write is taken only when the block is idle
// reset (aresetn low, synchronous) clears the register file and every phase
// through valid bits and loads the reset cycles_per_sample
// a finished result waits in the output register while the sink stalls; the
// block takes the next word meanwhile and only holds a later tick at its end
module nes_apu_tone_mixer_unit #(
    parameter int REG_COUNT       = 16,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,   // cycles_per_sample, q8.16
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // reg_addr [3:0], reg_data [11:4]
    input  logic        s_tuser,       // mode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // mixed_level [14:0], noise_level [26:15]
);

    localparam int RAW = $clog2(REG_COUNT);
    localparam int PW  = 16 + PHASE_FRAC_BITS;              // phase width
    localparam int SHL = (PHASE_FRAC_BITS >= 16) ? PHASE_FRAC_BITS - 16 : 0;
    localparam int SHR = (PHASE_FRAC_BITS < 16) ? 16 - PHASE_FRAC_BITS : 0;
    localparam int IW  = 24 + SHL;                          // increment width
    localparam int CW  = $clog2(PW);
    localparam int TW  = PW + 4;                            // 10*qt - 3*tnum
    localparam int DW  = PW + 12;                           // 2250*qt
    localparam int NW  = DW + 15;                           // 32767*(d-n)

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDREG, ST_VLOAD, ST_VWAIT, ST_MOD, ST_VUPD,
        ST_MIX1, ST_MIX2, ST_MIX3, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration register
    logic [23:0] cps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cps_reg <= 24'd2443637;
        end else if (cfg_wr_en) begin
            cps_reg <= cfg_wr_data;
        end
    end

    // sound register file: memory plus valid bits standing in for the zero reset
    logic [7:0]           rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [7:0]           rf_rdata_reg;
    logic                 rf_rvalid_reg;
    logic [RAW-1:0]       rf_raddr;
    logic [RAW-1:0]       rf_waddr;
    logic                 rf_we;
    logic [3:0]           fetch_cnt_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign rf_waddr = RAW'(s_tdata[3:0]);
    assign rf_we    = s_tvalid && s_tready && (s_tuser == nesmix_pkg::FLAG_WRITE)
                      && (32'(s_tdata[3:0]) < 32'(REG_COUNT));
    assign rf_raddr = RAW'(nesmix_pkg::fetch_addr(fetch_cnt_reg));

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= s_tdata[11:4];
        end
        rf_rdata_reg <= rf_mem[rf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg  <= '0;
            rf_rvalid_reg <= 1'b0;
        end else begin
            if (rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            rf_rvalid_reg <= rf_valid_reg[rf_raddr];
        end
    end

    // phase memory, one entry per voice
    logic [PW-1:0] ph_mem [4];
    logic [3:0]    ph_valid_reg;
    logic [PW-1:0] ph_rdata_reg;
    logic          ph_rvalid_reg;
    logic [1:0]    voice_reg;
    logic          ph_we;
    logic [PW-1:0] ph_wdata;

    always_ff @(posedge aclk) begin
        if (ph_we) begin
            ph_mem[voice_reg] <= ph_wdata;
        end
        ph_rdata_reg <= ph_mem[voice_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg  <= '0;
            ph_rvalid_reg <= 1'b0;
        end else begin
            if (ph_we) begin
                ph_valid_reg[voice_reg] <= 1'b1;
            end
            ph_rvalid_reg <= ph_valid_reg[voice_reg];
        end
    end

    // fetched registers, each read at a fixed place
    logic [7:0] hold_reg [nesmix_pkg::FETCH_COUNT];
    logic [7:0] rf_value;

    assign rf_value = rf_rvalid_reg ? rf_rdata_reg : 8'd0;

    // period of the current voice, scaled by the phase fraction
    logic [10:0] len_sel;
    logic [15:0] base_sel;
    logic [PW-1:0] q_sel;

    always_comb begin
        len_sel  = 11'd0;
        base_sel = 16'd0;
        case (voice_reg)
            nesmix_pkg::VOICE_P1:  len_sel = {hold_reg[2][2:0], hold_reg[1]};
            nesmix_pkg::VOICE_P2:  len_sel = {hold_reg[5][2:0], hold_reg[4]};
            nesmix_pkg::VOICE_TRI: len_sel = {hold_reg[7][2:0], hold_reg[6]};
            default:               len_sel = 11'd0;
        endcase
        if (voice_reg == nesmix_pkg::VOICE_NSE) begin
            base_sel = (16'(nesmix_pkg::noise_period(hold_reg[9][3:0])) + 16'd1) << 4;
        end else if (len_sel != 11'd0) begin
            base_sel = (16'(len_sel) + 16'd1) << 4;
        end
        q_sel = PW'(base_sel) << PHASE_FRAC_BITS;
    end

    // bit-serial modulo of phase and increment by the same period
    logic [PW-1:0] q_reg;
    logic          qzero_reg;
    logic [PW-1:0] rp_reg, ri_reg;
    logic [PW-1:0] pd_reg, id_reg;
    logic [CW-1:0] mod_cnt_reg;
    logic [PW:0]   rp_sh, ri_sh;
    logic [PW-1:0] rp_next, ri_next;
    logic [IW-1:0] inc;

    assign inc   = (IW'(cps_reg) << SHL) >> SHR;
    assign rp_sh = {rp_reg, pd_reg[PW-1]};
    assign ri_sh = {ri_reg, id_reg[PW-1]};
    assign rp_next = (rp_sh >= {1'b0, q_reg}) ? PW'(rp_sh - {1'b0, q_reg}) : PW'(rp_sh);
    assign ri_next = (ri_sh >= {1'b0, q_reg}) ? PW'(ri_sh - {1'b0, q_reg}) : PW'(ri_sh);

    // per-voice evaluation on the reduced phase
    logic [1:0]    duty_code;
    logic [3:0]    vol;
    logic [PW+2:0] p8, dq;
    logic          pulse_hi;
    logic [3:0]    pulse_f;
    logic [PW:0]   p2, tnum_calc;
    logic [PW+3:0] p15;
    logic [PW:0]   wsum;

    always_comb begin
        duty_code = (voice_reg == nesmix_pkg::VOICE_P1) ? hold_reg[0][7:6] : hold_reg[3][7:6];
        vol       = (voice_reg == nesmix_pkg::VOICE_P1) ? hold_reg[0][3:0] : hold_reg[3][3:0];
        p8        = (PW+3)'(rp_reg) << 3;
        case (duty_code)
            2'd0:    dq = (PW+3)'(q_reg);
            2'd1:    dq = (PW+3)'(q_reg) << 1;
            2'd2:    dq = (PW+3)'(q_reg) << 2;
            default: dq = ((PW+3)'(q_reg) << 2) + ((PW+3)'(q_reg) << 1);
        endcase
        pulse_hi  = qzero_reg || (p8 <= dq);
        pulse_f   = pulse_hi ? (4'd15 - vol) : 4'd15;
        p2        = (PW+1)'(rp_reg) << 1;
        tnum_calc = qzero_reg ? '0 :
                    (p2 < (PW+1)'(q_reg)) ? p2 : (((PW+1)'(q_reg) - (PW+1)'(rp_reg)) << 1);
        p15       = ((PW+4)'(rp_reg) << 4) - (PW+4)'(rp_reg);
        wsum      = (PW+1)'(rp_reg) + (PW+1)'(ri_reg);
        if (qzero_reg) begin
            ph_wdata = '0;
        end else if (wsum >= (PW+1)'(q_reg)) begin
            ph_wdata = PW'(wsum - (PW+1)'(q_reg));
        end else begin
            ph_wdata = PW'(wsum);
        end
    end

    assign ph_we = (state_reg == ST_VUPD);

    // mix datapath
    logic [3:0]    f0_reg, f1_reg;
    logic [PW:0]   tnum_reg;
    logic [PW-1:0] qt_reg;
    logic          noise_hi_reg;
    logic [7:0]    ff_reg;
    logic [TW-1:0] tsub_reg;
    logic [DW-1:0] d_reg, n_reg;
    logic [NW-1:0] num_reg, dv_reg;
    logic [14:0]   quo_reg;
    logic [3:0]    div_cnt_reg;
    logic [DW-1:0] d_calc, n_prod, e_calc;
    logic [TW-1:0] tsub_calc;

    always_comb begin
        d_calc = (DW'(qt_reg) << 11) + (DW'(qt_reg) << 7) + (DW'(qt_reg) << 6)
               + (DW'(qt_reg) << 3) + (DW'(qt_reg) << 1);
        tsub_calc = (TW'(qt_reg) << 3) + (TW'(qt_reg) << 1)
                  - ((TW'(tnum_reg) << 1) + TW'(tnum_reg));
        n_prod = DW'(ff_reg) * DW'(tsub_reg);
        e_calc = d_reg - n_reg;
    end

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            fetch_cnt_reg <= '0;
            voice_reg     <= '0;
            mod_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
        end else begin
            // in the output state the load below owns tvalid
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    fetch_cnt_reg <= '0;
                    voice_reg     <= nesmix_pkg::VOICE_P1;
                    if (s_tvalid && (s_tuser == nesmix_pkg::FLAG_TICK)) begin
                        state_reg <= ST_RDREG;
                    end
                end
                ST_RDREG: begin
                    // read data is registered, so it holds the value for the previous fetch slot
                    fetch_cnt_reg <= fetch_cnt_reg + 4'd1;
                    if (fetch_cnt_reg != 4'd0) begin
                        hold_reg[fetch_cnt_reg - 4'd1] <= rf_value;
                    end
                    if (fetch_cnt_reg == 4'(nesmix_pkg::FETCH_COUNT)) begin
                        state_reg <= ST_VLOAD;
                    end
                end
                ST_VLOAD: begin
                    q_reg     <= q_sel;
                    qzero_reg <= (q_sel == '0);
                    state_reg <= ST_VWAIT;
                end
                ST_VWAIT: begin
                    rp_reg      <= '0;
                    ri_reg      <= '0;
                    pd_reg      <= ph_rvalid_reg ? ph_rdata_reg : '0;
                    id_reg      <= PW'(inc);
                    mod_cnt_reg <= CW'(PW - 1);
                    state_reg   <= qzero_reg ? ST_VUPD : ST_MOD;
                end
                ST_MOD: begin
                    rp_reg      <= rp_next;
                    ri_reg      <= ri_next;
                    pd_reg      <= pd_reg << 1;
                    id_reg      <= id_reg << 1;
                    mod_cnt_reg <= mod_cnt_reg - CW'(1);
                    if (mod_cnt_reg == '0) begin
                        state_reg <= ST_VUPD;
                    end
                end
                ST_VUPD: begin
                    if (qzero_reg) begin
                        rp_reg <= '0;
                    end
                    case (voice_reg)
                        nesmix_pkg::VOICE_P1: f0_reg <= pulse_f;
                        nesmix_pkg::VOICE_P2: f1_reg <= pulse_f;
                        nesmix_pkg::VOICE_TRI: begin
                            tnum_reg <= tnum_calc;
                            qt_reg   <= qzero_reg ? PW'(1) : q_reg;
                        end
                        default: noise_hi_reg <= (p15 <= (PW+4)'(q_reg));
                    endcase
                    voice_reg <= voice_reg + 2'd1;
                    state_reg <= (voice_reg == nesmix_pkg::VOICE_NSE) ? ST_MIX1 : ST_VLOAD;
                end
                ST_MIX1: begin
                    ff_reg    <= {4'd0, f0_reg} * {4'd0, f1_reg};
                    tsub_reg  <= tsub_calc;
                    d_reg     <= d_calc;
                    state_reg <= ST_MIX2;
                end
                ST_MIX2: begin
                    n_reg     <= n_prod;
                    state_reg <= ST_MIX3;
                end
                ST_MIX3: begin
                    num_reg     <= (NW'(e_calc) << 15) - NW'(e_calc);
                    dv_reg      <= NW'(d_reg) << 14;
                    quo_reg     <= '0;
                    div_cnt_reg <= 4'd14;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (num_reg >= dv_reg) begin
                        num_reg <= num_reg - dv_reg;
                        quo_reg <= {quo_reg[13:0], 1'b1};
                    end else begin
                        quo_reg <= {quo_reg[13:0], 1'b0};
                    end
                    dv_reg      <= dv_reg >> 1;
                    div_cnt_reg <= div_cnt_reg - 4'd1;
                    if (div_cnt_reg == 4'd0) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0,
                                         noise_hi_reg ? nesmix_pkg::noise_amp(hold_reg[8][3:0])
                                                      : 12'd0,
                                         quo_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    logic chk_mod_ok, chk_mix_ok, chk_div_ok, chk_tick_acc;

    assign chk_mod_ok   = (state_reg != ST_MOD) || ((rp_reg < q_reg) && (ri_reg < q_reg));
    assign chk_mix_ok   = (state_reg != ST_MIX3) || (n_reg <= d_reg);
    assign chk_div_ok   = (state_reg != ST_OUT) || (num_reg < NW'(d_reg));
    assign chk_tick_acc = s_tvalid && s_tready && (s_tuser == nesmix_pkg::FLAG_TICK);

    `ASSERT_CLKED(a_mod_rem_below_period, aclk, aresetn, chk_mod_ok, "phase remainder too big")
    `ASSERT_CLKED(a_mix_bounded, aclk, aresetn, chk_mix_ok, "mix product over denominator")
    `ASSERT_CLKED(a_div_rem, aclk, aresetn, chk_div_ok, "divide remainder not below divisor")
    `ASSERT_NEVER(a_tick_blocks, aclk, aresetn, $past(chk_tick_acc) && s_tready, "ready after tick")

endmodule

/* tb/sv/tb_nes_apu_tone_mixer_unit.sv */
`timescale 1ns / 1ps
module tb_nes_apu_tone_mixer_unit;

    // generous cycle budget: ~550 ticks plus stalls and drains,
    // taken many times over
    localparam int CYCLE_LIMIT = 3000000;
    // settle time after the last result before a register write or the end
    localparam int DRAIN_CYCLES = 400;
    localparam logic [23:0] CPS_RESET = 24'd2443637;

    typedef struct packed {
        logic [11:0] noise;
        logic [14:0] mixed;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // shadow of the block's state
    logic [7:0]  snd_regs [16];
    logic [63:0] phase_acc [4];
    logic [23:0] cps_shadow;

    sample_t     pending_samples [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          steady_flow = 1'b0;   // when set neither side idles

    nes_apu_tone_mixer_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sink side: random back-pressure
    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= 14);
    end

    // result checker
    always @(posedge aclk) begin
        sample_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sample_t'(m_tdata[26:0]);
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: mixed %0d noise %0d", got.mixed, got.noise);
            end else begin
                want = pending_samples.pop_front();
                if (got.mixed !== want.mixed || got.noise !== want.noise) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: mixed exp %0d got %0d, noise exp %0d got %0d",
                                 want.mixed, got.mixed, want.noise, got.noise);
                end
            end
        end
    end

    function automatic logic [63:0] voice_period(input logic [10:0] len);
        return (64'd16 * (len + 64'd1)) << 16;
    endfunction

    // phase step: reduce then add a sample's worth of cycles
    function automatic void step_phase(input int v, input logic [63:0] q);
        if (q == 0)
            phase_acc[v] = 0;
        else
            phase_acc[v] = (phase_acc[v] + {40'd0, cps_shadow} % q) % q;
    endfunction

    // factor (15 - vol) while the pulse is high, 15 while low
    function automatic logic [63:0] pulse_gain(input int v, input logic [7:0] ctl,
                                               input logic [10:0] len,
                                               output logic [63:0] q);
        logic [63:0] duty;
        logic [63:0] vol;
        vol  = ctl[3:0];
        case (ctl[7:6])
            2'd0: duty = 1;
            2'd1: duty = 2;
            2'd2: duty = 4;
            default: duty = 6;
        endcase
        if (len == 0) begin
            q = 0;
            phase_acc[v] = 0;
            return 15 - vol;
        end
        q = voice_period(len);
        phase_acc[v] = phase_acc[v] % q;
        return (8 * phase_acc[v] <= duty * q) ? 15 - vol : 64'd15;
    endfunction

    // work out the output word of one tick and advance all phases
    function automatic sample_t tick_sample();
        logic [63:0] q0, q1, q2, q3, qt, tnum, f0, f1, d, n, mix, p;
        logic [10:0] tlen;
        sample_t s;
        f0 = pulse_gain(0, snd_regs[nesmix_pkg::REG_P1_CTL],
                        {snd_regs[nesmix_pkg::REG_P1_HI][2:0],
                         snd_regs[nesmix_pkg::REG_P1_LO]}, q0);
        f1 = pulse_gain(1, snd_regs[nesmix_pkg::REG_P2_CTL],
                        {snd_regs[nesmix_pkg::REG_P2_HI][2:0],
                         snd_regs[nesmix_pkg::REG_P2_LO]}, q1);
        tlen = {snd_regs[nesmix_pkg::REG_TRI_HI][2:0], snd_regs[nesmix_pkg::REG_TRI_LO]};
        q2 = 0;
        if (tlen == 0) begin
            phase_acc[2] = 0;
            qt = 1;
            tnum = 0;
        end else begin
            q2 = voice_period(tlen);
            phase_acc[2] = phase_acc[2] % q2;
            p = phase_acc[2];
            qt = q2;
            tnum = (2 * p < q2) ? 2 * p : 2 * (q2 - p);
        end
        d = 2250 * qt;
        n = f0 * f1 * (10 * qt - 3 * tnum);
        mix = (64'd32767 * (d - n)) / d;
        // noise: tabled period, high for the first fifteenth
        case (snd_regs[nesmix_pkg::REG_NSE_PER][3:0])
            4'd0: q3 = 4;     4'd1: q3 = 8;     4'd2: q3 = 16;    4'd3: q3 = 32;
            4'd4: q3 = 64;    4'd5: q3 = 96;    4'd6: q3 = 128;   4'd7: q3 = 160;
            4'd8: q3 = 202;   4'd9: q3 = 254;   4'd10: q3 = 380;  4'd11: q3 = 508;
            4'd12: q3 = 762;  4'd13: q3 = 1016; 4'd14: q3 = 2034; default: q3 = 4068;
        endcase
        q3 = (16 * (q3 + 1)) << 16;
        phase_acc[3] = phase_acc[3] % q3;
        s.mixed = mix[14:0];
        s.noise = (15 * phase_acc[3] <= q3) ?
                  12'((64'd32767 * snd_regs[nesmix_pkg::REG_NSE_VOL][3:0]) / 150) : 12'd0;
        step_phase(0, q0);
        step_phase(1, q1);
        step_phase(2, q2);
        step_phase(3, q3);
        return s;
    endfunction

    // send one word; leaves tvalid high at the falling edge after acceptance
    task automatic send_word(input logic mode, input logic [3:0] addr, input logic [7:0] data);
        if (!steady_flow && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, data, addr};
        do @(posedge aclk); while (!s_tready);
        if (mode == nesmix_pkg::FLAG_WRITE)
            snd_regs[addr] = data;
        else
            pending_samples.push_back(tick_sample());
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [7:0] data);
        send_word(nesmix_pkg::FLAG_WRITE, addr, data);
    endtask

    task automatic tick();
        send_word(nesmix_pkg::FLAG_TICK, 4'd0, 8'($urandom));
    endtask

    // stop sending and wait for every pending result plus the block's tail
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_cps(input logic [23:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cps_shadow = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // corner cases: zero and maximum lengths, every duty, volume extremes, noise table ends
    task automatic test_directed();
        tick();                                         // all registers zero: both pulses high
        write_reg(nesmix_pkg::REG_P1_CTL, 8'h0F);       // duty 1/8, full volume
        write_reg(nesmix_pkg::REG_P1_LO, 8'hFF);
        write_reg(nesmix_pkg::REG_P1_HI, 8'hFF);        // maximum length, upper bits ignored
        write_reg(nesmix_pkg::REG_P2_CTL, 8'hF0);       // duty 6/8, volume 0
        write_reg(nesmix_pkg::REG_P2_LO, 8'h01);
        tick();
        write_reg(nesmix_pkg::REG_P2_CTL, 8'h4F);       // duty 2/8
        write_reg(nesmix_pkg::REG_TRI_LO, 8'h00);
        write_reg(nesmix_pkg::REG_TRI_HI, 8'h07);       // triangle length bits 10..8 all set
        write_reg(nesmix_pkg::REG_NSE_VOL, 8'hFF);
        write_reg(nesmix_pkg::REG_NSE_PER, 8'h00);      // shortest noise period
        tick();
        tick();
        write_reg(nesmix_pkg::REG_P1_CTL, 8'h8F);       // duty 4/8
        write_reg(nesmix_pkg::REG_NSE_PER, 8'h0F);      // longest noise period
        tick();
        write_reg(nesmix_pkg::REG_P1_LO, 8'h00);
        write_reg(nesmix_pkg::REG_P1_HI, 8'h00);        // back to zero length: phase held at 0
        write_reg(nesmix_pkg::REG_TRI_HI, 8'h00);
        write_reg(nesmix_pkg::REG_TRI_LO, 8'h03);
        tick();
        write_reg(4'd15, 8'hAA);                        // unused slots still store
        write_reg(4'd1, 8'h55);
        tick();
    endtask

    task automatic random_word();
        logic [3:0] addr;
        logic [7:0] data;
        if ($urandom_range(99) < 50) begin
            tick();
            return;
        end
        case ($urandom_range(9))
            0: addr = nesmix_pkg::REG_P1_CTL;  1: addr = nesmix_pkg::REG_P2_CTL;
            2: addr = nesmix_pkg::REG_P1_LO;   3: addr = nesmix_pkg::REG_P2_LO;
            4: addr = nesmix_pkg::REG_TRI_LO;  5: addr = nesmix_pkg::REG_NSE_VOL;
            6: addr = nesmix_pkg::REG_NSE_PER; 7: addr = nesmix_pkg::REG_P1_HI;
            8: addr = nesmix_pkg::REG_P2_HI;   default: addr = 4'($urandom);
        endcase
        data = 8'($urandom);
        // keep high length bits mostly clear so periods stay short and wrap often
        if ((addr == nesmix_pkg::REG_P1_HI || addr == nesmix_pkg::REG_P2_HI) &&
            $urandom_range(99) < 60)
            data[2:0] = 3'd0;
        if ((addr == nesmix_pkg::REG_P1_LO || addr == nesmix_pkg::REG_P2_LO ||
             addr == nesmix_pkg::REG_TRI_LO) && $urandom_range(99) < 50)
            data = 8'($urandom_range(15));
        write_reg(addr, data);
    endtask

    // extremes of the sample step, including a frozen phase
    task automatic test_step_extremes();
        set_cps(24'd65536);
        repeat (20) random_word();
        set_cps(24'hFFFFFF);
        repeat (20) random_word();
        set_cps(24'd0);
        repeat (20) random_word();
    endtask

    task automatic test_random();
        set_cps(CPS_RESET);
        repeat (350) random_word();
        set_cps(24'($urandom_range(65536, 24'hFFFFFF)));
        steady_flow = 1'b1;                      // long stretch with no idling
        repeat (300) random_word();
        steady_flow = 1'b0;
        set_cps(24'($urandom));
        repeat (350) random_word();
    endtask

    initial begin
        for (int i = 0; i < 16; i++) snd_regs[i] = '0;
        for (int i = 0; i < 4; i++) phase_acc[i] = '0;
        cps_shadow = CPS_RESET;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_step_extremes();
        test_random();
        drain();
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
